[hw/rtl/npf_pkg.sv]
package npf_pkg;

    // Request width and derived datapath widths
    localparam int SIZE_WIDTH  = 16;
    localparam int CAND_W      = SIZE_WIDTH + 1;          // candidate / result width
    localparam int DIV_W       = SIZE_WIDTH / 2 + 2;      // trial divisor, > sqrt(2^CAND_W)
    localparam int SQ_W        = 2 * DIV_W;               // divisor squared
    localparam int BIT_W       = $clog2(CAND_W);          // bit index into candidate
    localparam int IN_TDATA_W  = ((SIZE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CAND_W + 7) / 8) * 8;

    // Smallest prime, first trial divisor and its square
    localparam logic [CAND_W-1:0] MIN_PRIME = CAND_W'(2);
    localparam logic [DIV_W-1:0]  FIRST_DIV = DIV_W'(2);
    localparam logic [SQ_W-1:0]   FIRST_SQ  = SQ_W'(4);

endpackage

[hw/rtl/next_prime_finder_unit.sv]
// Operation: after a request is accepted, each trial division runs through CHECK, DIV and
//   EVAL; each candidate tries divisors from 2 up to its first factor, or to
//   floor(sqrt(c)) for the answer.
// Throughput: one word at a time; the next request is taken the cycle after a result is
//   made, and a finished word waits in the output register while the next request runs.
// Reset: synchronous, active low; clears the sequencer and output valid only.
module next_prime_finder_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [npf_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,   // [15:0] requested_size
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [npf_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata    // [16:0] prime_size, rest zero
);
    import npf_pkg::*;

    // Sequencer: CHECK tests d*d <= c, DIV runs the remainder unit, EVAL
    // decides between next divisor and next candidate.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EVAL  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic               r_out_valid, n_out_valid;
    logic [CAND_W-1:0]  r_cand, n_cand;       // current candidate
    logic [DIV_W-1:0]   r_div, n_div;         // trial divisor
    logic [SQ_W-1:0]    r_sq, n_sq;           // r_div squared, kept incrementally
    logic [DIV_W-1:0]   r_rem, n_rem;         // partial remainder
    logic [BIT_W-1:0]   r_bit, n_bit;         // candidate bit fed next, MSB first
    logic [CAND_W-1:0]  r_out, n_out;         // result register

    logic [SIZE_WIDTH-1:0] req;
    logic [DIV_W:0]        rem_sh;
    logic [DIV_W:0]        div_ext;
    logic [DIV_W:0]        rem_sub;
    logic                  sq_le_cand;
    logic                  out_free;

    assign req        = i_s_axis_tdata[SIZE_WIDTH-1:0];
    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign sq_le_cand = r_sq <= {{(SQ_W-CAND_W){1'b0}}, r_cand};

    // Shared restoring remainder step: one candidate bit per cycle
    assign rem_sh  = {r_rem, r_cand[r_bit]};
    assign div_ext = {1'b0, r_div};
    assign rem_sub = rem_sh - div_ext;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-CAND_W){1'b0}}, r_out};

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_cand      = r_cand;
        n_div       = r_div;
        n_sq        = r_sq;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_out       = r_out;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    // requests below 2 start at 2
                    if ({1'b0, req} < MIN_PRIME) begin
                        n_cand = MIN_PRIME;
                    end else begin
                        n_cand = {1'b0, req};
                    end
                    n_div   = FIRST_DIV;
                    n_sq    = FIRST_SQ;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sq_le_cand) begin
                    n_rem   = '0;
                    n_bit   = BIT_W'(CAND_W - 1);
                    n_state = ST_DIV;
                end else if (out_free) begin
                    // no divisor up to sqrt: candidate is prime
                    n_out       = r_cand;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (rem_sh >= div_ext) begin
                    n_rem = rem_sub[DIV_W-1:0];
                end else begin
                    n_rem = rem_sh[DIV_W-1:0];
                end
                if (r_bit == '0) begin
                    n_state = ST_EVAL;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            ST_EVAL: begin
                if (r_rem == '0) begin
                    // divisor found: move to the next candidate
                    n_cand = r_cand + 1'b1;
                    n_div  = FIRST_DIV;
                    n_sq   = FIRST_SQ;
                end else begin
                    // (d+1)^2 = d^2 + 2d + 1
                    n_div = r_div + 1'b1;
                    n_sq  = r_sq + {{(SQ_W-DIV_W-1){1'b0}}, r_div, 1'b1};
                end
                n_state = ST_CHECK;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        r_div  <= n_div;
        r_sq   <= n_sq;
        r_rem  <= n_rem;
        r_bit  <= n_bit;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    // trial divisor never drops below 2 while working
    a_div_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_EVAL) |-> (r_div >= FIRST_DIV))
        else $error("trial divisor below 2");

    // partial remainder stays below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV || r_state == ST_EVAL) |-> (r_rem < r_div))
        else $error("remainder out of range");

    // a found prime is held in CHECK only while the output register is still full
    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && $past(r_state) == ST_CHECK && !sq_le_cand) |->
            r_out_valid)
        else $error("prime held back without output pending");

    // a newly produced word is at least 2
    a_out_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK && !sq_le_cand && out_free) |=>
            (r_out_valid && r_out >= MIN_PRIME))
        else $error("result below smallest prime");
`endif

endmodule
